// File: hw/rtl/bsa_pkg.sv
package bsa_pkg;

   localparam int unsigned WordBits  = 32;
   localparam int unsigned BitAw     = 5;
   localparam int unsigned IndexBits = 10;
   localparam int unsigned SlotBits  = 11;
   localparam int unsigned RemBits   = 6;

   localparam logic [SlotBits-1:0] SlotCountReset = 11'd1024;

   localparam logic OP_MARK = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_MODIFY = 3'b010,
      ST_SCAN   = 3'b100
   } state_type;

   // Outcome of a search of one map word for a clear bit.
   typedef struct packed {
      logic             found;
      logic [BitAw-1:0] pos;
      logic             last;   // no slot above this word lies below the size
   } search_result_type;

endpackage

// File: hw/rtl/bsa_ram.sv
module bsa_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bsa_free_search.sv
module bsa_free_search import bsa_pkg::*; (
   input  logic [WordBits-1:0] word,
   input  logic [BitAw-1:0]    lo_pos,
   input  logic [SlotBits-1:0] rem,
   output search_result_type   result
);

   logic [RemBits-1:0]  rem_clip;
   logic [WordBits-1:0] avail;

   // rem = size - word base; only bits below it are real slots
   assign rem_clip = (rem > SlotBits'(WordBits)) ? RemBits'(WordBits) : RemBits'(rem);

   always_comb begin
      for (int j = 0; j < WordBits; j++) begin
         avail[j] = !word[j] && (BitAw'(j) >= lo_pos) && (RemBits'(j) < rem_clip);
      end
   end

   always_comb begin
      result.found = |avail;
      result.pos   = '0;
      result.last  = (rem <= SlotBits'(WordBits));
      for (int j = WordBits - 1; j >= 0; j--) begin
         if (avail[j]) begin
            result.pos = BitAw'(j);
         end
      end
   end

endmodule

// File: hw/rtl/bitmap_slot_allocator.sv
// Channel   | Ports                                         | Beat accepted
// ----------+-----------------------------------------------+--------------------------
// request   | start, busy, req_operation, req_slot_index    | start && !busy
// response  | rsp_strobe, rsp_status, rsp_first_free,       | every cycle rsp_strobe is
//           | rsp_is_full                                   | high (no backpressure)
// config    | csr_wr_en, csr_wr_data (slot_count)           | csr_wr_en
//
// An out-of-range index answers in the cycle after acceptance with no map access.
// A mark or free is a read-modify-write of one map word: the word is read into the
// RAM read register, then the response beat is registered as the word is written back.
// A mark of the slot the first-free pointer names scans on, one map word per cycle.
// busy drops in the cycle the response beat is shown, so the next beat can be taken then.
// Reset (synchronous) clears the per-word valid bits: a word never written reads as all
// free, so no clearing pass is needed. The receiver cannot stall; each beat shows once.
module bitmap_slot_allocator import bsa_pkg::*; #(
   parameter int unsigned MAX_SLOTS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_operation,
   input  logic [IndexBits-1:0] req_slot_index,
   output logic                 rsp_strobe,
   output logic                 rsp_status,
   output logic [SlotBits-1:0]  rsp_first_free,
   output logic                 rsp_is_full,
   input  logic                 csr_wr_en,
   input  logic [SlotBits-1:0]  csr_wr_data
);

   // Indices stop at 1023, so map storage never exceeds 1024 slots; slots above that
   // are never marked and always read as free.
   localparam int unsigned MapSlots = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;
   localparam int unsigned MapWords = (MapSlots + WordBits - 1) / WordBits;
   localparam int unsigned WordAw   = (MapWords > 1) ? $clog2(MapWords) : 1;
   localparam int unsigned SizeCap  = (MAX_SLOTS < 2047) ? MAX_SLOTS : 2047;

   localparam logic [WordAw-1:0]   LastWord = WordAw'(MapWords - 1);
   localparam logic [SlotBits-1:0] MapEnd   = SlotBits'(MapWords * WordBits);

   // configuration
   logic [SlotBits-1:0] slot_count_ff, slot_count_in;
   logic [SlotBits-1:0] eff_size;

   // item control
   state_type           state_ff, state_in;
   logic                op_ff, op_in;
   logic [IndexBits-1:0] idx_ff, idx_in;
   logic [SlotBits-1:0] size_ff, size_in;
   logic [WordAw-1:0]   word_ff, word_in;
   logic                rd_valid_ff, rd_valid_in;

   // allocator state outside the map
   logic [SlotBits-1:0] ptr_ff, ptr_in;
   logic                full_ff, full_in;
   logic [MapWords-1:0] valid_ff, valid_in;

   // response beat
   logic                strobe_ff, strobe_in;
   logic                status_ff, status_in;
   logic [SlotBits-1:0] first_free_ff, first_free_in;
   logic                is_full_ff, is_full_in;

   // map memory
   logic                ram_wr_en;
   logic [WordBits-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [WordAw-1:0]   ram_rd_addr;
   logic [WordBits-1:0] ram_rd_data;

   // search
   logic [WordBits-1:0] map_word;
   logic [WordBits-1:0] new_word;
   logic [WordBits-1:0] search_word;
   logic [BitAw-1:0]    search_lo;
   logic [SlotBits-1:0] word_base;
   logic [SlotBits-1:0] search_rem;
   search_result_type   search;

   logic accept;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign eff_size = (slot_count_ff > SlotBits'(SizeCap)) ? SlotBits'(SizeCap) : slot_count_ff;

   // word never written since reset reads as all free
   assign map_word  = rd_valid_ff ? ram_rd_data : '0;
   assign new_word  = (op_ff == OP_MARK) ? (map_word | (WordBits'(1) << idx_ff[BitAw-1:0]))
                                         : (map_word & ~(WordBits'(1) << idx_ff[BitAw-1:0]));
   assign word_base = SlotBits'(word_ff) << BitAw;
   assign search_rem = size_ff - word_base;

   always_comb begin
      if (state_ff == ST_SCAN) begin
         search_word = map_word;
         search_lo   = '0;
      end else begin
         search_word = new_word;
         search_lo   = idx_ff[BitAw-1:0];
      end
   end

   bsa_free_search u_search (
      .word   (search_word),
      .lo_pos (search_lo),
      .rem    (search_rem),
      .result (search)
   );

   bsa_ram #(
      .WIDTH (WordBits),
      .DEPTH (MapWords)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (word_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      slot_count_in = csr_wr_en ? csr_wr_data : slot_count_ff;

      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      size_in       = size_ff;
      word_in       = word_ff;
      rd_valid_in   = rd_valid_ff;
      ptr_in        = ptr_ff;
      full_in       = full_ff;
      valid_in      = valid_ff;
      strobe_in     = 1'b0;
      status_in     = status_ff;
      first_free_in = first_free_ff;
      is_full_in    = is_full_ff;
      ram_wr_en     = 1'b0;
      ram_wr_data   = new_word;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = WordAw'(req_slot_index >> BitAw);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (SlotBits'(req_slot_index) >= eff_size) begin
                  // rejected: report unchanged state, no map access
                  strobe_in     = 1'b1;
                  status_in     = STATUS_RANGE;
                  first_free_in = ptr_ff;
                  is_full_in    = full_ff;
               end else begin
                  ram_rd_en   = 1'b1;
                  rd_valid_in = valid_ff[ram_rd_addr];
                  op_in       = req_operation;
                  idx_in      = req_slot_index;
                  size_in     = eff_size;
                  word_in     = ram_rd_addr;
                  state_in    = ST_MODIFY;
               end
            end
         end
         ST_MODIFY: begin
            // write-back of the one word this item touches; the scan only reads words
            // above it and the next item reads after this write lands, so no forwarding
            ram_wr_en          = 1'b1;
            valid_in[word_ff]  = 1'b1;
            strobe_in          = 1'b1;
            status_in          = STATUS_OK;
            state_in           = ST_IDLE;
            if (op_ff == OP_FREE) begin
               if (SlotBits'(idx_ff) < ptr_ff) begin
                  ptr_in = SlotBits'(idx_ff);
               end
               full_in = 1'b0;
            end else if (ptr_ff == SlotBits'(idx_ff)) begin
               if (search.found) begin
                  ptr_in = word_base + SlotBits'(search.pos);
               end else if (search.last) begin
                  ptr_in  = size_ff;
                  full_in = 1'b1;
               end else if (word_ff == LastWord) begin
                  ptr_in = MapEnd;
               end else begin
                  strobe_in   = 1'b0;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = word_ff + WordAw'(1);
                  rd_valid_in = valid_ff[ram_rd_addr];
                  word_in     = ram_rd_addr;
                  state_in    = ST_SCAN;
               end
            end
            if (strobe_in) begin
               first_free_in = ptr_in;
               is_full_in    = full_in;
            end
         end
         ST_SCAN: begin
            strobe_in = 1'b1;
            status_in = STATUS_OK;
            state_in  = ST_IDLE;
            if (search.found) begin
               ptr_in = word_base + SlotBits'(search.pos);
            end else if (search.last) begin
               ptr_in  = size_ff;
               full_in = 1'b1;
            end else if (word_ff == LastWord) begin
               ptr_in = MapEnd;
            end else begin
               strobe_in   = 1'b0;
               ram_rd_en   = 1'b1;
               ram_rd_addr = word_ff + WordAw'(1);
               rd_valid_in = valid_ff[ram_rd_addr];
               word_in     = ram_rd_addr;
               state_in    = ST_SCAN;
            end
            if (strobe_in) begin
               first_free_in = ptr_in;
               is_full_in    = full_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SlotCountReset;
         state_ff      <= ST_IDLE;
         ptr_ff        <= '0;
         full_ff       <= 1'b0;
         valid_ff      <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         slot_count_ff <= slot_count_in;
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         full_ff       <= full_in;
         valid_ff      <= valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      size_ff       <= size_in;
      word_ff       <= word_in;
      rd_valid_ff   <= rd_valid_in;
      status_ff     <= status_in;
      first_free_ff <= first_free_in;
      is_full_ff    <= is_full_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_first_free = first_free_ff;
   assign rsp_is_full    = is_full_ff;

endmodule
